>>> design/acc_pkg.sv
// Package with shared constants and status codes for the arc center core.
`timescale 1ns / 1ps

package acc_pkg;

   localparam int CENTER_BITS = 40;
   localparam int STATUS_BITS = 2;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_COLLINEAR = 2'd1,
      STATUS_SATURATED = 2'd2
   } status_type;

endpackage

>>> design/acc_if.sv
// Request and response channel interfaces of the arc center core.
`timescale 1ns / 1ps

interface acc_req_if #(
   parameter int COORD_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] mid_x;
   logic signed [COORD_BITS-1:0] mid_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;

   modport source (output valid, start_x, start_y, mid_x, mid_y, end_x, end_y, input ready);
   modport sink (input valid, start_x, start_y, mid_x, mid_y, end_x, end_y, output ready);
endinterface

interface acc_rsp_if;
   import acc_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [CENTER_BITS-1:0] center_x;
   logic signed [CENTER_BITS-1:0] center_y;
   logic [STATUS_BITS-1:0]        status;

   modport source (output valid, center_x, center_y, status, input ready);
   modport sink (input valid, center_x, center_y, status, output ready);
endinterface

>>> design/acc_front.sv
// Front pipeline: differences, products, numerators and divider operands.
`timescale 1ns / 1ps

module acc_front import acc_pkg::*; #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 8,
   parameter int NM         = 62,
   parameter int DW         = 34
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         valid_in,
   input  logic signed [COORD_BITS-1:0] x0_in_w,
   input  logic signed [COORD_BITS-1:0] y0_in_w,
   input  logic signed [COORD_BITS-1:0] x1_in_w,
   input  logic signed [COORD_BITS-1:0] y1_in_w,
   input  logic signed [COORD_BITS-1:0] x2_in_w,
   input  logic signed [COORD_BITS-1:0] y2_in_w,
   output logic                         valid_out,
   output logic [NM-1:0]                magx,
   output logic [NM-1:0]                magy,
   output logic [DW-1:0]                dmag,
   output logic                         negx,
   output logic                         negy,
   output logic                         coll
);

   localparam int C    = COORD_BITS;
   localparam int D1   = C + 1;
   localparam int SQW  = 2 * C + 2;
   localparam int DENW = 2 * C + 3;
   localparam int PAW  = C + DENW;
   localparam int PBW  = D1 + SQW;
   localparam int NS   = 3 * C + 6;

   // Stage 1
   logic                 v1_ff;
   logic signed [C-1:0]  x0_1_ff, y0_1_ff;
   logic signed [D1-1:0] bx_1_ff, by_1_ff, cx_1_ff, cy_1_ff, sx_1_ff, sy_1_ff;
   logic                 same_1_ff;
   // Stage 2
   logic                  v2_ff;
   logic signed [C-1:0]   x0_2_ff, y0_2_ff;
   logic signed [D1-1:0]  bx_2_ff, by_2_ff, cx_2_ff, cy_2_ff, sx_2_ff, sy_2_ff;
   logic                  same_2_ff;
   logic signed [SQW-1:0] bxx_ff, byy_ff, cxx_ff, cyy_ff, pbc_ff, pcb_ff;
   // Stage 3
   logic                   v3_ff;
   logic signed [C-1:0]    x0_3_ff, y0_3_ff;
   logic signed [D1-1:0]   bx_3_ff, by_3_ff, cx_3_ff, cy_3_ff, sx_3_ff, sy_3_ff;
   logic                   same_3_ff;
   logic signed [SQW-1:0]  b2_ff, c2_ff;
   logic signed [DENW-1:0] den_3_ff;
   logic signed [DENW-1:0] cross_in;
   // Stage 4
   logic                   v4_ff;
   logic signed [D1-1:0]   sx_4_ff, sy_4_ff;
   logic                   same_4_ff;
   logic signed [DENW-1:0] den_4_ff;
   logic signed [PAW-1:0]  x0d_ff, y0d_ff;
   logic signed [PBW-1:0]  cyb2_ff, byc2_ff, bxc2_ff, cxb2_ff;
   // Stage 5
   logic                   v5_ff;
   logic signed [NS-1:0]   nx_ff, ny_ff, nx_in, ny_in;
   logic signed [DENW-1:0] den_5_ff, den_5_in;
   logic                   coll_5_ff;
   // Stage 6
   logic                 v6_ff;
   logic [NM-1:0]        magx_ff, magy_ff;
   logic [DW-1:0]        dmag_ff;
   logic                 negx_ff, negy_ff, coll_6_ff;
   logic [NS-1:0]        absx_in, absy_in;
   logic [DENW-1:0]      absd_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= valid_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_comb begin
      cross_in = DENW'(pbc_ff) - DENW'(pcb_ff);
      if (same_4_ff) begin
         nx_in    = NS'(sx_4_ff);
         ny_in    = NS'(sy_4_ff);
         den_5_in = DENW'(2);
      end else begin
         nx_in    = NS'(x0d_ff) + NS'(cyb2_ff) - NS'(byc2_ff);
         ny_in    = NS'(y0d_ff) + NS'(bxc2_ff) - NS'(cxb2_ff);
         den_5_in = den_4_ff;
      end
      absx_in = nx_ff[NS-1] ? NS'(-nx_ff) : NS'(nx_ff);
      absy_in = ny_ff[NS-1] ? NS'(-ny_ff) : NS'(ny_ff);
      absd_in = den_5_ff[DENW-1] ? DENW'(-den_5_ff) : DENW'(den_5_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x0_1_ff   <= x0_in_w;
         y0_1_ff   <= y0_in_w;
         bx_1_ff   <= D1'(x1_in_w) - D1'(x0_in_w);
         by_1_ff   <= D1'(y1_in_w) - D1'(y0_in_w);
         cx_1_ff   <= D1'(x2_in_w) - D1'(x0_in_w);
         cy_1_ff   <= D1'(y2_in_w) - D1'(y0_in_w);
         sx_1_ff   <= D1'(x0_in_w) + D1'(x1_in_w);
         sy_1_ff   <= D1'(y0_in_w) + D1'(y1_in_w);
         same_1_ff <= (x0_in_w == x2_in_w) && (y0_in_w == y2_in_w);

         x0_2_ff   <= x0_1_ff;
         y0_2_ff   <= y0_1_ff;
         bx_2_ff   <= bx_1_ff;
         by_2_ff   <= by_1_ff;
         cx_2_ff   <= cx_1_ff;
         cy_2_ff   <= cy_1_ff;
         sx_2_ff   <= sx_1_ff;
         sy_2_ff   <= sy_1_ff;
         same_2_ff <= same_1_ff;
         bxx_ff    <= SQW'(bx_1_ff * bx_1_ff);
         byy_ff    <= SQW'(by_1_ff * by_1_ff);
         cxx_ff    <= SQW'(cx_1_ff * cx_1_ff);
         cyy_ff    <= SQW'(cy_1_ff * cy_1_ff);
         pbc_ff    <= SQW'(bx_1_ff * cy_1_ff);
         pcb_ff    <= SQW'(by_1_ff * cx_1_ff);

         x0_3_ff   <= x0_2_ff;
         y0_3_ff   <= y0_2_ff;
         bx_3_ff   <= bx_2_ff;
         by_3_ff   <= by_2_ff;
         cx_3_ff   <= cx_2_ff;
         cy_3_ff   <= cy_2_ff;
         sx_3_ff   <= sx_2_ff;
         sy_3_ff   <= sy_2_ff;
         same_3_ff <= same_2_ff;
         b2_ff     <= bxx_ff + byy_ff;
         c2_ff     <= cxx_ff + cyy_ff;
         den_3_ff  <= cross_in <<< 1;

         sx_4_ff   <= sx_3_ff;
         sy_4_ff   <= sy_3_ff;
         same_4_ff <= same_3_ff;
         den_4_ff  <= den_3_ff;
         x0d_ff    <= PAW'(x0_3_ff * den_3_ff);
         y0d_ff    <= PAW'(y0_3_ff * den_3_ff);
         cyb2_ff   <= PBW'(cy_3_ff * b2_ff);
         byc2_ff   <= PBW'(by_3_ff * c2_ff);
         bxc2_ff   <= PBW'(bx_3_ff * c2_ff);
         cxb2_ff   <= PBW'(cx_3_ff * b2_ff);

         nx_ff     <= nx_in;
         ny_ff     <= ny_in;
         den_5_ff  <= den_5_in;
         coll_5_ff <= !same_4_ff && (den_4_ff == '0);

         magx_ff   <= NM'(absx_in) << FRAC_BITS;
         magy_ff   <= NM'(absy_in) << FRAC_BITS;
         dmag_ff   <= DW'(absd_in);
         negx_ff   <= nx_ff[NS-1] ^ den_5_ff[DENW-1];
         negy_ff   <= ny_ff[NS-1] ^ den_5_ff[DENW-1];
         coll_6_ff <= coll_5_ff;
      end
   end

   assign valid_out = v6_ff;
   assign magx      = magx_ff;
   assign magy      = magy_ff;
   assign dmag      = dmag_ff;
   assign negx      = negx_ff;
   assign negy      = negy_ff;
   assign coll      = coll_6_ff;

endmodule

>>> design/acc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module acc_div import acc_pkg::*; #(
   parameter int NM = 62,
   parameter int DW = 34,
   parameter int TW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          valid_in,
   input  logic [NM-1:0] num_in,
   input  logic [DW-1:0] den_in,
   input  logic [TW-1:0] tag_in,
   output logic          valid_out,
   output logic [NM-1:0] quot,
   output logic [DW-1:0] rem,
   output logic [DW-1:0] den_out,
   output logic [TW-1:0] tag_out
);

   logic          v_ff   [NM];
   logic [DW-1:0] rem_ff [NM];
   logic [NM-1:0] nq_ff  [NM];
   logic [DW-1:0] d_ff   [NM];
   logic [TW-1:0] tag_ff [NM];

   for (genvar i = 0; i < NM; i++) begin : g_stage
      logic          pv;
      logic [DW-1:0] prem;
      logic [NM-1:0] pnq;
      logic [DW-1:0] pd;
      logic [TW-1:0] ptag;
      logic [DW:0]   t;
      logic          ge;
      logic [DW:0]   nrem;

      if (i == 0) begin : g_first
         assign pv   = valid_in;
         assign prem = '0;
         assign pnq  = num_in;
         assign pd   = den_in;
         assign ptag = tag_in;
      end else begin : g_next
         assign pv   = v_ff[i-1];
         assign prem = rem_ff[i-1];
         assign pnq  = nq_ff[i-1];
         assign pd   = d_ff[i-1];
         assign ptag = tag_ff[i-1];
      end

      always_comb begin
         t    = {prem, pnq[NM-1]};
         ge   = t >= {1'b0, pd};
         nrem = ge ? t - {1'b0, pd} : t;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= nrem[DW-1:0];
            nq_ff[i]  <= {pnq[NM-2:0], ge};
            d_ff[i]   <= pd;
            tag_ff[i] <= ptag;
         end
      end
   end

   assign valid_out = v_ff[NM-1];
   assign quot      = nq_ff[NM-1];
   assign rem       = rem_ff[NM-1];
   assign den_out   = d_ff[NM-1];
   assign tag_out   = tag_ff[NM-1];

endmodule

>>> design/acc_back.sv
// Output stage: rounding, sign, saturation and the response register.
`timescale 1ns / 1ps

module acc_back import acc_pkg::*; #(
   parameter int NM = 62,
   parameter int DW = 34
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          valid_in,
   input  logic [NM-1:0]                 qx,
   input  logic [DW-1:0]                 rx,
   input  logic [NM-1:0]                 qy,
   input  logic [DW-1:0]                 ry,
   input  logic [DW-1:0]                 den,
   input  logic                          negx,
   input  logic                          negy,
   input  logic                          coll,
   output logic                          valid_out,
   output logic signed [CENTER_BITS-1:0] center_x,
   output logic signed [CENTER_BITS-1:0] center_y,
   output logic [STATUS_BITS-1:0]        status
);

   localparam int QW = (NM + 1 > CENTER_BITS + 1) ? NM + 1 : CENTER_BITS + 1;
   localparam logic [QW-1:0] LIM = QW'(1) << (CENTER_BITS - 1);

   logic                   v_ff;
   logic [CENTER_BITS-1:0] cx_ff, cy_ff, cx_in, cy_in;
   status_type             st_ff, st_in;
   logic [QW-1:0]          qrx, qry;
   logic                   satx, saty;

   always_comb begin
      qrx  = QW'(qx) + QW'({rx, 1'b0} >= {1'b0, den});
      qry  = QW'(qy) + QW'({ry, 1'b0} >= {1'b0, den});
      satx = negx ? (qrx > LIM) : (qrx > LIM - QW'(1));
      saty = negy ? (qry > LIM) : (qry > LIM - QW'(1));
      if (satx) begin
         cx_in = negx ? CENTER_BITS'(LIM) : CENTER_BITS'(LIM - QW'(1));
      end else begin
         cx_in = negx ? CENTER_BITS'(-qrx) : CENTER_BITS'(qrx);
      end
      if (saty) begin
         cy_in = negy ? CENTER_BITS'(LIM) : CENTER_BITS'(LIM - QW'(1));
      end else begin
         cy_in = negy ? CENTER_BITS'(-qry) : CENTER_BITS'(qry);
      end
      st_in = (satx || saty) ? STATUS_SATURATED : STATUS_OK;
      if (coll) begin
         cx_in = '0;
         cy_in = '0;
         st_in = STATUS_COLLINEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         st_ff <= st_in;
      end
   end

   assign valid_out = v_ff;
   assign center_x  = cx_ff;
   assign center_y  = cy_ff;
   assign status    = st_ff;

endmodule

>>> design/arc_center_three_points_core.sv
// Top level: circle center through three arc points, fully pipelined.
// Requests pass through six front stages, one divider stage per numerator bit and
// one output register.
// Throughput is one request per cycle; a stalled response holds the whole pipeline.
// Synchronous active-high reset clears the valid bits only.
`timescale 1ns / 1ps

module arc_center_three_points_core import acc_pkg::*; #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 8
) (
   input  logic clock,
   input  logic reset,
   acc_req_if.sink   req,
   acc_rsp_if.source rsp
);

   localparam int NM = 3 * COORD_BITS + 6 + FRAC_BITS;
   localparam int DW = 2 * COORD_BITS + 2;

   logic          en;
   logic          fv, dvx, dvy, bv;
   logic [NM-1:0] magx, magy, qx, qy;
   logic [DW-1:0] dmag, rx, ry, dx, dy;
   logic          negx, negy, coll;
   logic [1:0]    tagx;
   logic [0:0]    tagy;

   assign en        = !bv || rsp.ready;
   assign req.ready = en;

   acc_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .NM(NM), .DW(DW)) u_front (
      .clock(clock), .reset(reset), .en(en), .valid_in(req.valid),
      .x0_in_w(req.start_x), .y0_in_w(req.start_y), .x1_in_w(req.mid_x),
      .y1_in_w(req.mid_y), .x2_in_w(req.end_x), .y2_in_w(req.end_y),
      .valid_out(fv), .magx(magx), .magy(magy), .dmag(dmag),
      .negx(negx), .negy(negy), .coll(coll)
   );

   acc_div #(.NM(NM), .DW(DW), .TW(2)) u_div_x (
      .clock(clock), .reset(reset), .en(en), .valid_in(fv),
      .num_in(magx), .den_in(dmag), .tag_in({coll, negx}),
      .valid_out(dvx), .quot(qx), .rem(rx), .den_out(dx), .tag_out(tagx)
   );

   acc_div #(.NM(NM), .DW(DW), .TW(1)) u_div_y (
      .clock(clock), .reset(reset), .en(en), .valid_in(fv),
      .num_in(magy), .den_in(dmag), .tag_in(negy),
      .valid_out(dvy), .quot(qy), .rem(ry), .den_out(dy), .tag_out(tagy)
   );

   acc_back #(.NM(NM), .DW(DW)) u_back (
      .clock(clock), .reset(reset), .en(en), .valid_in(dvx && dvy),
      .qx(qx), .rx(rx), .qy(qy), .ry(ry), .den(dx | dy),
      .negx(tagx[0]), .negy(tagy[0]), .coll(tagx[1]),
      .valid_out(bv), .center_x(rsp.center_x), .center_y(rsp.center_y),
      .status(rsp.status)
   );

   assign rsp.valid = bv;

endmodule
